FILE: hdl/ipr_pkg.sv
// shared types, constants and codes for the indexed pool with ring list
`default_nettype none

package ipr_pkg;

    // default pool depth and the pool size register value after reset
    localparam int          POOL_DEPTH_DEF = 256;
    localparam logic [8:0]  SIZE_RESET     = 9'd256;

    // operation codes carried in the kind field
    localparam logic [2:0] KIND_ADD       = 3'd0;
    localparam logic [2:0] KIND_REMOVE    = 3'd1;
    localparam logic [2:0] KIND_PEEK_HEAD = 3'd2;
    localparam logic [2:0] KIND_PEEK_IDX  = 3'd3;
    localparam logic [2:0] KIND_PEEK_ADV  = 3'd4;
    localparam logic [2:0] KIND_SET_IDX   = 3'd5;
    localparam logic [2:0] KIND_CLEAR     = 3'd6;

    // command beat
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  entry_index;
        logic [63:0] write_data;
    } ipr_req_t;

    // result beat
    typedef struct packed {
        logic        found;
        logic [7:0]  result_index;
        logic [63:0] read_data;
    } ipr_rsp_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ADD_FREE,
        ST_ADD_HEAD,
        ST_ADD_LINK,
        ST_ADD_LINKH,
        ST_RM_ENTRY,
        ST_RM_PREV,
        ST_RM_NEXT,
        ST_PEEK,
        ST_INDEX
    } ipr_state_t;

endpackage

`default_nettype wire

FILE: hdl/ipr_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module ipr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/indexed_pool_with_ring_list_unit.sv
// pool of linked entries: free list plus circular doubly linked list in one ram
// add and remove follow a chain of dependent link reads through the single ram read
//   port; peeks and set index read their entry once before the result beat
// failures caught on the accept cycle (full, empty, bad index) answer in the next cycle
// clear writes one entry per cycle over the saturated pool_size; result the cycle after
// one command at a time, the next one taken in the cycle its predecessor's result shows;
//   after reset a clearing pass over min(256, POOL_DEPTH) entries runs with busy high
`default_nettype none

module indexed_pool_with_ring_list_unit #(
    parameter int POOL_DEPTH = ipr_pkg::POOL_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire ipr_pkg::ipr_req_t request,
    output logic                  done,
    output ipr_pkg::ipr_rsp_t     result,
    input  wire logic             cfg_we,
    input  wire logic [8:0]       cfg_data
);

    import ipr_pkg::*;

    localparam int IW = $clog2(POOL_DEPTH);
    localparam int LW = IW + 1;
    localparam int WW = 64 + 2 * LW;
    localparam int CW = (LW > 8) ? LW : 8;
    localparam int SW = (LW > 9) ? LW : 9;
    localparam logic [LW-1:0] NIL = LW'(POOL_DEPTH);
    localparam int RESET_SIZE = (int'(SIZE_RESET) > POOL_DEPTH) ? POOL_DEPTH
                                                                : int'(SIZE_RESET);

    ipr_state_t state_reg, state_next;

    logic              init_reg, init_next;
    logic              done_reg, done_next;
    ipr_rsp_t          rsp_reg, rsp_next;
    ipr_req_t          req_reg, req_next;
    logic [8:0]        pool_size_reg, pool_size_next;
    logic [LW-1:0]     active_reg, active_next;
    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     free_reg, free_next;
    logic [LW-1:0]     cnt_reg, cnt_next;
    logic [LW-1:0]     node_reg, node_next;
    logic [LW-1:0]     aux_reg, aux_next;
    logic [LW-1:0]     aux2_reg, aux2_next;
    logic [63+LW:0]    word_reg, word_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [IW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_wdata;
    logic [WW-1:0]     ram_rdata;
    logic [63:0]       w_data;
    logic [LW-1:0]     w_next;
    logic [LW-1:0]     w_prev;

    logic [63:0]       rd_data;
    logic [LW-1:0]     rd_next;
    logic [LW-1:0]     rd_prev;
    logic              rd_in_use;
    logic [63:0]       word_data;
    logic [LW-1:0]     word_link;
    logic              head_nil;
    logic              pool_full;
    logic              idx_ok;
    logic [IW-1:0]     idx_addr;
    logic              cnt_last;
    logic [SW-1:0]     size_wide;
    logic [LW-1:0]     sat_size;
    ipr_rsp_t          add_rsp;

    // entry ram: data word, next link, previous link
    ipr_ram #(
        .WIDTH (WW),
        .DEPTH (POOL_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata = {w_data, w_next, w_prev};

    // fields of the word read last cycle and of the saved word
    assign rd_data   = ram_rdata[WW-1 -: 64];
    assign rd_next   = ram_rdata[2*LW-1 -: LW];
    assign rd_prev   = ram_rdata[LW-1:0];
    assign rd_in_use = (rd_prev != NIL);
    assign word_data = word_reg[63+LW -: 64];
    assign word_link = word_reg[LW-1:0];

    // command checks
    assign head_nil  = (head_reg == NIL);
    assign pool_full = (free_reg == NIL);
    assign idx_ok    = (CW'(request.entry_index) < CW'(active_reg));
    assign idx_addr  = IW'(request.entry_index);
    assign cnt_last  = (LW'(cnt_reg + 1'b1) == active_reg);

    // pool size clamped into 1 .. POOL_DEPTH
    assign size_wide = SW'(pool_size_reg);
    assign sat_size  = (size_wide == '0) ? LW'(1)
                     : (size_wide > SW'(POOL_DEPTH)) ? LW'(POOL_DEPTH)
                     : LW'(size_wide);

    assign add_rsp = '{found: 1'b1, result_index: 8'(node_reg), read_data: 64'd0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.kind)
                        KIND_ADD:       state_next = pool_full ? ST_IDLE : ST_ADD_FREE;
                        KIND_REMOVE:    state_next = idx_ok ? ST_RM_ENTRY : ST_IDLE;
                        KIND_PEEK_HEAD: state_next = head_nil ? ST_IDLE : ST_PEEK;
                        KIND_PEEK_ADV:  state_next = head_nil ? ST_IDLE : ST_PEEK;
                        KIND_PEEK_IDX:  state_next = idx_ok ? ST_INDEX : ST_IDLE;
                        KIND_SET_IDX:   state_next = idx_ok ? ST_INDEX : ST_IDLE;
                        KIND_CLEAR:     state_next = ST_SWEEP;
                        default:        state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP:     state_next = cnt_last ? ST_IDLE : ST_SWEEP;
            ST_ADD_FREE:  state_next = head_nil ? ST_IDLE : ST_ADD_HEAD;
            ST_ADD_HEAD:  state_next = ST_ADD_LINK;
            ST_ADD_LINK:  state_next = (aux_reg == head_reg) ? ST_IDLE : ST_ADD_LINKH;
            ST_ADD_LINKH: state_next = ST_IDLE;
            ST_RM_ENTRY:
            begin
                state_next = (!rd_in_use || rd_next == node_reg) ? ST_IDLE : ST_RM_PREV;
            end
            ST_RM_PREV:   state_next = (aux_reg == aux2_reg) ? ST_IDLE : ST_RM_NEXT;
            ST_RM_NEXT:   state_next = ST_IDLE;
            ST_PEEK:      state_next = ST_IDLE;
            ST_INDEX:     state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath, ram accesses and result
    always_comb
    begin
        init_next      = init_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        pool_size_next = cfg_we ? cfg_data : pool_size_reg;
        active_next    = active_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        node_next      = node_reg;
        aux_next       = aux_reg;
        aux2_next      = aux2_reg;
        word_next      = word_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_raddr      = '0;
        w_data         = '0;
        w_next         = '0;
        w_prev         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    unique case (request.kind)
                        KIND_ADD:
                        begin
                            ram_raddr = free_reg[IW-1:0];
                            node_next = free_reg;
                            if (pool_full)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '0;
                            end
                        end
                        KIND_REMOVE, KIND_PEEK_IDX, KIND_SET_IDX:
                        begin
                            ram_raddr = idx_addr;
                            node_next = LW'(request.entry_index);
                            if (!idx_ok)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '0;
                            end
                        end
                        KIND_PEEK_HEAD, KIND_PEEK_ADV:
                        begin
                            ram_raddr = head_reg[IW-1:0];
                            if (head_nil)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '0;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            active_next = sat_size;
                            head_next   = NIL;
                            free_next   = '0;
                            cnt_next    = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    endcase
                end
            end

            // rebuild the free chain one entry per cycle
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IW-1:0];
                w_next    = cnt_last ? NIL : LW'(cnt_reg + 1'b1);
                w_prev    = NIL;
                cnt_next  = LW'(cnt_reg + 1'b1);
                if (cnt_last)
                begin
                    init_next = 1'b0;
                    if (!init_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{found: 1'b1, result_index: 8'd0, read_data: 64'd0};
                    end
                end
            end

            // pop the free head; an empty list gets a one entry ring
            ST_ADD_FREE:
            begin
                free_next = rd_next;
                if (head_nil)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = node_reg[IW-1:0];
                    w_data    = req_reg.write_data;
                    w_next    = node_reg;
                    w_prev    = node_reg;
                    head_next = node_reg;
                    done_next = 1'b1;
                    rsp_next  = add_rsp;
                end
                else
                begin
                    ram_raddr = head_reg[IW-1:0];
                end
            end

            // head word in hand: write the new entry, fetch the tail
            ST_ADD_HEAD:
            begin
                word_next = ram_rdata[WW-1:LW];
                aux_next  = rd_prev;
                ram_we    = 1'b1;
                ram_waddr = node_reg[IW-1:0];
                w_data    = req_reg.write_data;
                w_next    = head_reg;
                w_prev    = rd_prev;
                ram_raddr = rd_prev[IW-1:0];
            end

            // tail next link; tail and head can be the same entry
            ST_ADD_LINK:
            begin
                ram_we = 1'b1;
                w_data = rd_data;
                w_next = node_reg;
                if (aux_reg == head_reg)
                begin
                    ram_waddr = head_reg[IW-1:0];
                    w_prev    = node_reg;
                    done_next = 1'b1;
                    rsp_next  = add_rsp;
                end
                else
                begin
                    ram_waddr = aux_reg[IW-1:0];
                    w_prev    = rd_prev;
                end
            end

            // head previous link
            ST_ADD_LINKH:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_reg[IW-1:0];
                w_data    = word_data;
                w_next    = word_link;
                w_prev    = node_reg;
                done_next = 1'b1;
                rsp_next  = add_rsp;
            end

            // unlink the entry and push it on the free list
            ST_RM_ENTRY:
            begin
                if (!rd_in_use)
                begin
                    done_next = 1'b1;
                    rsp_next  = '0;
                end
                else
                begin
                    word_next = ram_rdata[WW-1:LW];
                    aux_next  = rd_prev;
                    aux2_next = rd_next;
                    ram_we    = 1'b1;
                    ram_waddr = node_reg[IW-1:0];
                    w_data    = rd_data;
                    w_next    = free_reg;
                    w_prev    = NIL;
                    free_next = node_reg;
                    if (head_reg == node_reg)
                    begin
                        head_next = (rd_next == node_reg) ? NIL : rd_next;
                    end
                    if (rd_next == node_reg)
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{found: 1'b1, result_index: 8'(node_reg),
                                      read_data: rd_data};
                    end
                    else
                    begin
                        ram_raddr = rd_prev[IW-1:0];
                    end
                end
            end

            // previous neighbor; with two entries it is also the next one
            ST_RM_PREV:
            begin
                ram_we    = 1'b1;
                ram_waddr = aux_reg[IW-1:0];
                w_data    = rd_data;
                w_next    = aux2_reg;
                if (aux_reg == aux2_reg)
                begin
                    w_prev    = aux_reg;
                    done_next = 1'b1;
                    rsp_next  = '{found: 1'b1, result_index: 8'(node_reg),
                                  read_data: word_data};
                end
                else
                begin
                    w_prev    = rd_prev;
                    ram_raddr = aux2_reg[IW-1:0];
                end
            end

            // next neighbor
            ST_RM_NEXT:
            begin
                ram_we    = 1'b1;
                ram_waddr = aux2_reg[IW-1:0];
                w_data    = rd_data;
                w_next    = rd_next;
                w_prev    = aux_reg;
                done_next = 1'b1;
                rsp_next  = '{found: 1'b1, result_index: 8'(node_reg),
                              read_data: word_data};
            end

            // head peek, optionally stepping the head
            ST_PEEK:
            begin
                done_next = 1'b1;
                rsp_next  = '{found: 1'b1, result_index: 8'(head_reg), read_data: rd_data};
                if (req_reg.kind == KIND_PEEK_ADV)
                begin
                    head_next = rd_next;
                end
            end

            // peek or set by index
            ST_INDEX:
            begin
                done_next = 1'b1;
                if (!rd_in_use)
                begin
                    rsp_next = '0;
                end
                else if (req_reg.kind == KIND_SET_IDX)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = node_reg[IW-1:0];
                    w_data    = req_reg.write_data;
                    w_next    = rd_next;
                    w_prev    = rd_prev;
                    rsp_next  = '{found: 1'b1, result_index: 8'(node_reg),
                                  read_data: 64'd0};
                end
                else
                begin
                    rsp_next = '{found: 1'b1, result_index: 8'(node_reg),
                                 read_data: rd_data};
                end
            end

            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // control registers; reset starts the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            init_reg      <= 1'b1;
            done_reg      <= 1'b0;
            pool_size_reg <= SIZE_RESET;
            active_reg    <= LW'(RESET_SIZE);
            head_reg      <= NIL;
            free_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            done_reg      <= done_next;
            pool_size_reg <= pool_size_next;
            active_reg    <= active_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        req_reg  <= req_next;
        node_reg <= node_next;
        aux_reg  <= aux_next;
        aux2_reg <= aux2_next;
        word_reg <= word_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    // a result beat follows an accepted command or a busy cycle
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(start && !busy) || $past(busy)))
        else $error("result beat without a command");

    // free list and ring never share their first entry
    a_heads_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        !(free_reg == head_reg && head_reg != NIL))
        else $error("free head equals list head");

    // between commands the list head is null or inside the active pool
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (head_reg == NIL || head_reg < active_reg))
        else $error("list head outside the active pool");

    // the clearing pass after reset reports nothing
    a_init_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(init_reg) |-> !done_reg)
        else $error("result beat from the reset clearing pass");

    // the sweep counter stays inside the active pool
    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (cnt_reg < active_reg))
        else $error("sweep beyond the active pool");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_indexed_pool_with_ring_list_unit.sv
// testbench for the indexed pool with ring list: directed table, then random phases
`timescale 1ns / 100ps

module tb_indexed_pool_with_ring_list_unit;

    import ipr_pkg::*;

    localparam int          DEPTH        = POOL_DEPTH_DEF;
    localparam logic [8:0]  NIL          = 9'(POOL_DEPTH_DEF);
    localparam logic [2:0]  KIND_UNKNOWN = 3'd7;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASES       = 10;
    localparam int          PHASE_ITEMS  = 50;

    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_TYPED,
        ROW_SIZE
    } row_kind_t;

    typedef struct {
        row_kind_t  what;
        ipr_req_t   req;
        ipr_rsp_t   rsp;
        logic [8:0] size;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    ipr_req_t   request;
    logic       done;
    ipr_rsp_t   result;
    logic       cfg_we;
    logic [8:0] cfg_data;

    // shadow copy of the pool
    logic [63:0] pool_data [DEPTH];
    logic [8:0]  pool_next [DEPTH];
    logic [8:0]  pool_prev [DEPTH];
    logic [8:0]  pool_head;
    logic [8:0]  pool_free;
    logic [8:0]  pool_size_reg;
    logic [8:0]  pool_active;

    ipr_rsp_t    rsp_due_q [$];
    script_row_t script_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          quiet_stretch = 1'b0;

    indexed_pool_with_ring_list_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, rsp_due_q.size());
            $display("** indexed_pool_with_ring_list_unit: FAILED **");
            $finish;
        end
    end

    // null links fall back to entry zero
    function automatic logic [8:0] ring_slot(logic [8:0] i);
        return (i < NIL) ? i : 9'd0;
    endfunction

    // clear: free chain over the saturated size, nothing in use
    function automatic void pool_rebuild();
        int n;
        int i;
        n = pool_size_reg;
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        pool_active = 9'(n);
        for (i = 0; i < n; i++)
        begin
            pool_prev[i] = NIL;
            pool_next[i] = (i + 1 < n) ? 9'(i + 1) : NIL;
        end
        pool_head = NIL;
        pool_free = 9'd0;
    endfunction

    function automatic void pool_reset();
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            pool_data[i] = '0;
            pool_next[i] = NIL;
            pool_prev[i] = NIL;
        end
        pool_size_reg = SIZE_RESET;
        pool_rebuild();
    endfunction

    function automatic bit pool_valid(logic [8:0] idx);
        return idx < pool_active && pool_prev[idx[7:0]] != NIL;
    endfunction

    // apply one command to the shadow pool and return its result beat
    function automatic ipr_rsp_t pool_apply(ipr_req_t req);
        ipr_rsp_t   rsp;
        logic [8:0] n;
        logic [8:0] h;
        logic [8:0] p;
        logic [8:0] nx;
        logic [8:0] pv;
        logic [8:0] idx;
        rsp = '0;
        idx = {1'b0, req.entry_index};
        case (req.kind)
            KIND_ADD:
            begin
                n = pool_free;
                if (n < NIL)
                begin
                    pool_free = pool_next[n[7:0]];
                    pool_data[n[7:0]] = req.write_data;
                    if (pool_head != NIL)
                    begin
                        h = ring_slot(pool_head);
                        p = ring_slot(pool_prev[h[7:0]]);
                        pool_next[n[7:0]] = h;
                        pool_prev[n[7:0]] = p;
                        pool_next[p[7:0]] = n;
                        pool_prev[h[7:0]] = n;
                    end
                    else
                    begin
                        pool_next[n[7:0]] = n;
                        pool_prev[n[7:0]] = n;
                        pool_head = n;
                    end
                    rsp.found = 1'b1;
                    rsp.result_index = n[7:0];
                end
            end
            KIND_REMOVE:
            begin
                if (pool_valid(idx))
                begin
                    nx = ring_slot(pool_next[idx[7:0]]);
                    pv = ring_slot(pool_prev[idx[7:0]]);
                    rsp.read_data = pool_data[idx[7:0]];
                    if (idx == pool_head)
                        pool_head = (nx == idx) ? NIL : nx;
                    pool_next[pv[7:0]] = nx;
                    pool_prev[nx[7:0]] = pv;
                    pool_prev[idx[7:0]] = NIL;
                    pool_next[idx[7:0]] = pool_free;
                    pool_free = idx;
                    rsp.found = 1'b1;
                    rsp.result_index = idx[7:0];
                end
            end
            KIND_PEEK_HEAD, KIND_PEEK_ADV:
            begin
                if (pool_head != NIL)
                begin
                    h = ring_slot(pool_head);
                    rsp.read_data = pool_data[h[7:0]];
                    rsp.found = 1'b1;
                    rsp.result_index = h[7:0];
                    if (req.kind == KIND_PEEK_ADV)
                        pool_head = pool_next[h[7:0]];
                end
            end
            KIND_PEEK_IDX:
            begin
                if (pool_valid(idx))
                begin
                    rsp.read_data = pool_data[idx[7:0]];
                    rsp.found = 1'b1;
                    rsp.result_index = idx[7:0];
                end
            end
            KIND_SET_IDX:
            begin
                if (pool_valid(idx))
                begin
                    pool_data[idx[7:0]] = req.write_data;
                    rsp.found = 1'b1;
                    rsp.result_index = idx[7:0];
                end
            end
            KIND_CLEAR:
            begin
                pool_rebuild();
                rsp.found = 1'b1;
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    // random command, indexes mostly taken from the live ring
    function automatic ipr_req_t rand_cmd();
        ipr_req_t   req;
        int         pick;
        int         steps;
        logic [8:0] cur;
        pick = $urandom_range(0, 99);
        if (pick < 32)      req.kind = KIND_ADD;
        else if (pick < 52) req.kind = KIND_REMOVE;
        else if (pick < 60) req.kind = KIND_PEEK_HEAD;
        else if (pick < 72) req.kind = KIND_PEEK_IDX;
        else if (pick < 82) req.kind = KIND_PEEK_ADV;
        else if (pick < 95) req.kind = KIND_SET_IDX;
        else if (pick < 98) req.kind = KIND_CLEAR;
        else                req.kind = KIND_UNKNOWN;
        cur = pool_head;
        if (cur != NIL && $urandom_range(0, 3) != 0)
        begin
            steps = $urandom_range(0, 7);
            repeat (steps) cur = pool_next[cur[7:0]];
            req.entry_index = cur[7:0];
        end
        else
            req.entry_index = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       req.write_data = '0;
            1:       req.write_data = '1;
            default: req.write_data = {$urandom, $urandom};
        endcase
        return req;
    endfunction

    // directed table builders
    function automatic void tab_cmd(logic [2:0] k, logic [7:0] ix, logic [63:0] d);
        script_row_t row;
        row.what = ROW_PREDICTED;
        row.req  = '{kind: k, entry_index: ix, write_data: d};
        row.rsp  = '0;
        row.size = '0;
        script_q.push_back(row);
    endfunction

    function automatic void tab_typed(logic [2:0] k, logic [7:0] ix, logic [63:0] d,
                                      logic f, logic [7:0] ri, logic [63:0] rd);
        script_row_t row;
        row.what = ROW_TYPED;
        row.req  = '{kind: k, entry_index: ix, write_data: d};
        row.rsp  = '{found: f, result_index: ri, read_data: rd};
        row.size = '0;
        script_q.push_back(row);
    endfunction

    function automatic void tab_size(logic [8:0] v);
        script_row_t row;
        row.what = ROW_SIZE;
        row.req  = '0;
        row.rsp  = '0;
        row.size = v;
        script_q.push_back(row);
    endfunction

    // one command beat; the shadow pool is updated at the accepting edge
    task automatic send_cmd(ipr_req_t req, bit typed, ipr_rsp_t typed_rsp);
        ipr_rsp_t rsp;
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        rsp = pool_apply(req);
        rsp_due_q.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic sender_gap();
        if (!quiet_stretch && $urandom_range(0, 99) < 16)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // hold off until every result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (rsp_due_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pool_size(logic [8:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pool_size_reg = v;
    endtask

    // result check against the oldest expectation
    always @(posedge clk)
    begin : rsp_check
        ipr_rsp_t want;
        if (rst_n && done)
        begin
            if (rsp_due_q.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d index=%0d data=%h",
                         $time, result.found, result.result_index, result.read_data);
                errors++;
            end
            else
            begin
                want = rsp_due_q.pop_front();
                if (result.found !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, result.found);
                    errors++;
                end
                if (result.result_index !== want.result_index)
                begin
                    $display("%0t: result_index expected %0d actual %0d",
                             $time, want.result_index, result.result_index);
                    errors++;
                end
                if (result.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, result.read_data);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        logic [8:0] sz;
        int         ph;
        int         k;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        request  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        pool_reset();

        // empty pool after reset, invalid indexes, unknown kind
        tab_typed(KIND_PEEK_HEAD, 8'd0,   64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_ADV,  8'd0,   64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_REMOVE,    8'd0,   64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_IDX,  8'd255, 64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_SET_IDX,   8'd5,   '1,    1'b0, 8'd0, 64'd0);
        tab_typed(KIND_UNKNOWN,   8'd255, '1,    1'b0, 8'd0, 64'd0);
        // build a ring of three, walk and edit it
        tab_typed(KIND_ADD,       8'd255, 64'd0, 1'b1, 8'd0, 64'd0);
        tab_typed(KIND_ADD,       8'd0,   '1,    1'b1, 8'd1, 64'd0);
        tab_cmd(KIND_ADD,         8'd0,   64'h0123_4567_89AB_CDEF);
        tab_typed(KIND_PEEK_HEAD, 8'd0,   64'd0, 1'b1, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_ADV,  8'd0,   64'd0, 1'b1, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_HEAD, 8'd0,   64'd0, 1'b1, 8'd1, '1);
        tab_cmd(KIND_PEEK_IDX,    8'd2,   64'd0);
        tab_typed(KIND_SET_IDX,   8'd1,   64'hA5A5_5A5A_F00F_0FF0, 1'b1, 8'd1, 64'd0);
        tab_typed(KIND_REMOVE,    8'd1,   64'd0, 1'b1, 8'd1, 64'hA5A5_5A5A_F00F_0FF0);
        tab_typed(KIND_REMOVE,    8'd1,   64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_IDX,  8'd255, 64'd0, 1'b0, 8'd0, 64'd0);
        tab_cmd(KIND_ADD,         8'd0,   64'h8000_0000_0000_0001);
        // shrinking clear to one entry, then pool full
        tab_size(9'd1);
        tab_typed(KIND_CLEAR,     8'd0,   64'd0, 1'b1, 8'd0, 64'd0);
        tab_typed(KIND_PEEK_IDX,  8'd2,   64'd0, 1'b0, 8'd0, 64'd0);
        tab_typed(KIND_ADD,       8'd7,   '1,    1'b1, 8'd0, 64'd0);
        tab_typed(KIND_ADD,       8'd0,   '1,    1'b0, 8'd0, 64'd0);
        // out of range sizes saturate
        tab_size(9'd0);
        tab_typed(KIND_CLEAR,     8'd0,   64'd0, 1'b1, 8'd0, 64'd0);
        tab_cmd(KIND_ADD,         8'd0,   64'hFFFF_0000_FFFF_0000);
        tab_size(9'd511);
        tab_typed(KIND_CLEAR,     8'd0,   64'd0, 1'b1, 8'd0, 64'd0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (script_q[r])
        begin
            if (script_q[r].what == ROW_SIZE)
                write_pool_size(script_q[r].size);
            else
            begin
                send_cmd(script_q[r].req, script_q[r].what == ROW_TYPED, script_q[r].rsp);
                sender_gap();
            end
        end

        // random phases, each at its own pool size
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       sz = 9'd2;
                1:       sz = 9'd256;
                2:       sz = 9'd1;
                3:       sz = 9'($urandom_range(0, 511));
                4:       sz = 9'd511;
                default: sz = 9'($urandom_range(1, 24));
            endcase
            write_pool_size(sz);
            send_cmd('{kind: KIND_CLEAR, entry_index: 8'd0, write_data: 64'd0}, 1'b0, '0);
            quiet_stretch = (ph == 5);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (ph == 6 && k == PHASE_ITEMS / 2)
                    wait_drained();
                send_cmd(rand_cmd(), 1'b0, '0);
                sender_gap();
            end
        end

        // drain and settle
        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** indexed_pool_with_ring_list_unit: PASSED **");
        else
            $display("** indexed_pool_with_ring_list_unit: FAILED **");
        $finish;
    end

endmodule
